// ----- hdl/wafold_pkg.sv -----
// ----------------------------------------------------------------------------
// wafold_pkg
// Shared codes, field widths and controller/datapath interface types for the
// weighted overlap-add analysis fold block.
// ----------------------------------------------------------------------------
package wafold_pkg;

    // Field widths of the item and result channels
    localparam int MODE_W     = 2;
    localparam int COEF_IDX_W = 13;
    localparam int SAMPLE_W   = 24;
    localparam int BIN_W      = 10;
    localparam int FOLD_W     = 48;
    // Up to eight 24x24 products: a product needs 48 bits, eight of them 51
    localparam int ACC_W      = 51;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FFT_LEN_LOG2      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RATIO_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_LOG2      = 2'd2;

    localparam logic [3:0] FFT_L2_RST   = 4'd10;
    localparam logic [1:0] RATIO_L2_RST = 2'd0;
    localparam logic [2:0] OVL_L2_RST   = 3'd2;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    // Result kinds
    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_FOLD = 1'b1;

    localparam logic signed [FOLD_W-1:0] FOLD_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [FOLD_W-1:0] FOLD_MIN = 48'sh8000_0000_0000;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture the input beat
        logic coef_we;    // write window coefficient
        logic hist_push;  // write sample, advance hop counters
        logic rd_setup;   // compute first term, clear accumulator
        logic rd_issue;   // read one term from both memories
        logic out_note;   // load hop notice into output register
        logic out_fold;   // load folded bin into output register
    } wafold_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hop_hit;    // this push completes a hop
        logic term_more;  // another window term remains
        logic pipe_busy;  // multiply-accumulate pipe holds a term
        logic out_free;   // output register can take a result
    } wafold_sts_t;

endpackage

// ----- hdl/wafold_ctrl.sv -----
// ----------------------------------------------------------------------------
// wafold_ctrl
// Sequencer for loads, pushes and folded-bin reads; drives the datapath by
// command struct and watches its status.
// ----------------------------------------------------------------------------
module wafold_ctrl
    import wafold_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [MODE_W-1:0] s_mode,
    output logic              s_ready,
    input  wafold_sts_t       sts,
    output wafold_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_PUSH   = 3'd2;
    localparam logic [2:0] ST_NOTE   = 3'd3;
    localparam logic [2:0] ST_SETUP  = 3'd4;
    localparam logic [2:0] ST_FETCH  = 3'd5;
    localparam logic [2:0] ST_DRAIN  = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch = 1'b1;
                    unique case (s_mode)
                        MODE_LOAD: state_next = ST_LOAD;
                        MODE_PUSH: state_next = ST_PUSH;
                        MODE_READ: state_next = ST_SETUP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                cmd.coef_we = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_PUSH: begin
                cmd.hist_push = 1'b1;
                state_next    = sts.hop_hit ? ST_NOTE : ST_IDLE;
            end
            ST_NOTE: begin
                if (sts.out_free) begin
                    cmd.out_note = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SETUP: begin
                cmd.rd_setup = 1'b1;
                state_next   = ST_FETCH;
            end
            ST_FETCH: begin
                if (sts.term_more) begin
                    cmd.rd_issue = 1'b1;
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_fold = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/wafold_dp.sv -----
// ----------------------------------------------------------------------------
// wafold_dp
// Datapath: configuration registers, window and history memories, hop
// counters, term address generation, multiply-accumulate pipe, saturation
// and the output register.
// ----------------------------------------------------------------------------
module wafold_dp
    import wafold_pkg::*;
#(
    parameter int MAX_FFT_LEN    = 1024,
    parameter int MAX_WINDOW_LEN = 8192,
    parameter int HISTORY_DEPTH  = 16384
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  wafold_cmd_t                cmd,
    output wafold_sts_t                sts,
    input  logic [COEF_IDX_W-1:0]      s_coef_index,
    input  logic signed [SAMPLE_W-1:0] s_coef_value,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    input  logic [BIN_W-1:0]           s_bin_index,
    input  logic                       cfg_valid,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic                       m_kind,
    output logic [BIN_W-1:0]           m_bin_number,
    output logic signed [FOLD_W-1:0]   m_fold_value
);

    localparam int FFT_AW  = $clog2(MAX_FFT_LEN);
    localparam int NW      = FFT_AW + 1;
    localparam int WW      = FFT_AW + 4;
    localparam int WIN_AW  = $clog2(MAX_WINDOW_LEN);
    localparam int HIST_AW = $clog2(HISTORY_DEPTH);
    localparam int WCAP    = (MAX_WINDOW_LEN < HISTORY_DEPTH) ? MAX_WINDOW_LEN
                                                              : HISTORY_DEPTH;
    localparam logic [3:0]       FFT_L2_CAP = 4'(FFT_AW);
    localparam logic [HIST_AW:0] FILL_FULL  = (HIST_AW + 1)'(HISTORY_DEPTH);

    // Configuration
    logic [3:0] fft_l2_reg;
    logic [1:0] ratio_l2_reg;
    logic [2:0] ovl_l2_reg;

    // Latched input beat
    logic [COEF_IDX_W-1:0]      idx_reg;
    logic signed [SAMPLE_W-1:0] coef_val_reg;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic [BIN_W-1:0]           bin_reg;

    // Stream state
    logic [HIST_AW-1:0] wp_reg;
    logic [HIST_AW:0]   fill_reg;
    logic [FFT_AW-1:0]  phase_reg;
    logic [FFT_AW-1:0]  hop_cnt_reg;
    logic [FFT_AW-1:0]  rot_reg;
    logic [HIST_AW-1:0] hop_end_reg;

    // Read pipe
    logic [WW-1:0]              term_idx_reg;
    logic [WW-1:0]              term_idx_next;
    logic signed [SAMPLE_W-1:0] coef_q_reg;
    logic signed [SAMPLE_W-1:0] hist_q_reg;
    logic                       hvalid_reg;
    logic                       s1_valid_reg;
    logic                       s2_valid_reg;
    logic signed [FOLD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    // Output register
    logic                     m_valid_reg;
    logic                     m_kind_reg;
    logic [BIN_W-1:0]         m_bin_reg;
    logic signed [FOLD_W-1:0] m_fold_reg;

    logic signed [SAMPLE_W-1:0] coef_mem [MAX_WINDOW_LEN];
    logic signed [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];

    logic [3:0]               eff_l2;
    logic [3:0]               hop_l2;
    logic [NW-1:0]            fft_n;
    logic [NW-1:0]            hop_n;
    logic [FFT_AW-1:0]        fft_mask;
    logic [WW-1:0]            win_raw;
    logic [WW-1:0]            win_n;
    logic [NW-1:0]            cnt_inc;
    logic                     hop_hit;
    logic [FFT_AW-1:0]        phase_next;
    logic [FFT_AW-1:0]        hop_cnt_next;
    logic [HIST_AW-1:0]       wp_next;
    logic                     bin_ok;
    logic [FFT_AW-1:0]        first_term;
    logic [WIN_AW-1:0]        caddr;
    logic [HIST_AW-1:0]       haddr;
    logic                     coef_in_range;
    logic signed [FOLD_W-1:0] sat_val;

    // Transform, hop and window lengths, all powers of two except the clamp
    always_comb begin
        eff_l2   = (fft_l2_reg > FFT_L2_CAP) ? FFT_L2_CAP : fft_l2_reg;
        fft_n    = NW'(1) << eff_l2;
        fft_mask = FFT_AW'(fft_n - NW'(1));
        hop_l2   = (eff_l2 > {1'b0, ovl_l2_reg}) ? (eff_l2 - {1'b0, ovl_l2_reg}) : 4'd0;
        hop_n    = NW'(1) << hop_l2;
        win_raw  = WW'(1) << (5'(eff_l2) + 5'(ratio_l2_reg));
        win_n    = (32'(win_raw) > WCAP) ? WW'(WCAP) : win_raw;
    end

    always_comb begin
        cnt_inc      = NW'(hop_cnt_reg) + NW'(1);
        hop_hit      = (cnt_inc >= hop_n);
        hop_cnt_next = hop_hit ? '0 : FFT_AW'(cnt_inc);
        phase_next   = ((phase_reg & fft_mask) + FFT_AW'(1)) & fft_mask;
        wp_next      = wp_reg + HIST_AW'(1);
    end

    always_comb begin
        bin_ok        = (32'(bin_reg) < 32'(fft_n));
        first_term    = (FFT_AW'(bin_reg) - (rot_reg & fft_mask)) & fft_mask;
        term_idx_next = term_idx_reg + WW'(fft_n);
        caddr         = WIN_AW'(term_idx_reg);
        // oldest sample of the frame sits one window length behind the hop end
        haddr         = hop_end_reg + HIST_AW'(term_idx_reg) - HIST_AW'(win_n);
        coef_in_range = (32'(idx_reg) < 32'(MAX_WINDOW_LEN));
    end

    always_comb begin
        if ((&acc_reg[ACC_W-1:FOLD_W-1]) || !(|acc_reg[ACC_W-1:FOLD_W-1])) begin
            sat_val = acc_reg[FOLD_W-1:0];
        end else begin
            sat_val = acc_reg[ACC_W-1] ? FOLD_MIN : FOLD_MAX;
        end
    end

    always_comb begin
        sts.hop_hit   = hop_hit;
        sts.term_more = (term_idx_reg < win_n);
        sts.pipe_busy = s1_valid_reg || s2_valid_reg;
        sts.out_free  = !m_valid_reg || m_ready;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fft_l2_reg   <= FFT_L2_RST;
            ratio_l2_reg <= RATIO_L2_RST;
            ovl_l2_reg   <= OVL_L2_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FFT_LEN_LOG2:      fft_l2_reg   <= cfg_data;
                CFG_WINDOW_RATIO_LOG2: ratio_l2_reg <= cfg_data[1:0];
                CFG_OVERLAP_LOG2:      ovl_l2_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Input beat capture
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            idx_reg      <= s_coef_index;
            coef_val_reg <= s_coef_value;
            samp_reg     <= s_sample_value;
            bin_reg      <= s_bin_index;
        end
    end

    // Sample stream counters; fill count stands in for a zeroed history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            fill_reg    <= '0;
            phase_reg   <= '0;
            hop_cnt_reg <= '0;
            rot_reg     <= '0;
            hop_end_reg <= '0;
        end else if (cmd.hist_push) begin
            wp_reg      <= wp_next;
            phase_reg   <= phase_next;
            hop_cnt_reg <= hop_cnt_next;
            if (fill_reg != FILL_FULL) begin
                fill_reg <= fill_reg + (HIST_AW + 1)'(1);
            end
            if (hop_hit) begin
                rot_reg     <= phase_next;
                hop_end_reg <= wp_next;
            end
        end
    end

    // Window coefficient memory
    always_ff @(posedge aclk) begin
        if (cmd.coef_we && coef_in_range) begin
            coef_mem[WIN_AW'(idx_reg)] <= coef_val_reg;
        end
        if (cmd.rd_issue) begin
            coef_q_reg <= coef_mem[caddr];
        end
    end

    // History memory
    always_ff @(posedge aclk) begin
        if (cmd.hist_push) begin
            hist_mem[wp_reg] <= samp_reg;
        end
        if (cmd.rd_issue) begin
            hist_q_reg <= hist_mem[haddr];
            hvalid_reg <= (fill_reg > {1'b0, haddr});
        end
    end

    // Term index walks b, b + N, b + 2N, ... below the window length, b the bin less the rotation
    always_ff @(posedge aclk) begin
        if (cmd.rd_setup) begin
            term_idx_reg <= bin_ok ? WW'(first_term) : win_n;
        end else if (cmd.rd_issue) begin
            term_idx_reg <= term_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.rd_issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Multiply, then accumulate; unwritten history reads as zero
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            if (hvalid_reg) begin
                prod_reg <= coef_q_reg * hist_q_reg;
            end else begin
                prod_reg <= '0;
            end
        end
        if (cmd.rd_setup) begin
            acc_reg <= '0;
        end else if (s2_valid_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_note || cmd.out_fold) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_note) begin
            m_kind_reg <= KIND_NOTE;
            m_bin_reg  <= '0;
            m_fold_reg <= '0;
        end else if (cmd.out_fold) begin
            m_kind_reg <= KIND_FOLD;
            m_bin_reg  <= bin_reg;
            m_fold_reg <= sat_val;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_bin_number = m_bin_reg;
    assign m_fold_value = m_fold_reg;

endmodule

// ----- hdl/wola_analysis_fold_top.sv -----
// ----------------------------------------------------------------------------
// wola_analysis_fold_top
// STFT analysis front end: window load, sample history with hop notices,
// and folded-bin reads of the last completed frame.
// ----------------------------------------------------------------------------
// One item at a time. A push that completes a hop issues a notice; a read
// passes through the setup, fetch, drain and result states, fetch reading
// K = ceil(W / N) folded window terms (at most 8; none for a bin at or above
// N): the single-port window and history memories deliver one term per cycle
// into a registered multiply-accumulate pipe. A result parked in the output
// register does not block the next item, but a new result waits for the
// register to empty. The history store needs no clearing pass after reset:
// a fill count marks unwritten entries, which read as zero. MAX_FFT_LEN and
// HISTORY_DEPTH must be powers of two. Configuration writes are taken in any
// cycle and must only be issued while the block is idle.
module wola_analysis_fold_top
    import wafold_pkg::*;
#(
    parameter int MAX_FFT_LEN    = 1024,
    parameter int MAX_WINDOW_LEN = 8192,
    parameter int HISTORY_DEPTH  = 16384
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [MODE_W-1:0]          s_mode,
    input  logic [COEF_IDX_W-1:0]      s_coef_index,
    input  logic signed [SAMPLE_W-1:0] s_coef_value,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    input  logic [BIN_W-1:0]           s_bin_index,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_kind,
    output logic [BIN_W-1:0]           m_bin_number,
    output logic signed [FOLD_W-1:0]   m_fold_value,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    wafold_cmd_t cmd;
    wafold_sts_t sts;

    assign cfg_ready = 1'b1;

    wafold_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wafold_dp #(
        .MAX_FFT_LEN    (MAX_FFT_LEN),
        .MAX_WINDOW_LEN (MAX_WINDOW_LEN),
        .HISTORY_DEPTH  (HISTORY_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_coef_index   (s_coef_index),
        .s_coef_value   (s_coef_value),
        .s_sample_value (s_sample_value),
        .s_bin_index    (s_bin_index),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_kind         (m_kind),
        .m_bin_number   (m_bin_number),
        .m_fold_value   (m_fold_value)
    );

`ifndef SYNTHESIS
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_note || cmd.out_fold) |-> sts.out_free)
        else $error("result loaded into occupied output register");

    a_accept_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !sts.pipe_busy)
        else $error("input beat accepted while fold pipe busy");

    a_issue_fills_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |=> sts.pipe_busy)
        else $error("issued term did not enter fold pipe");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_fold |-> !$past(cmd.out_fold))
        else $error("two folded results back to back");
`endif

endmodule

// ----- dv/wola_fold_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wola_fold_checker
// Watches the item, result and register channels of the analysis fold block,
// keeps its own copy of window, sample history and hop state, predicts every
// result beat and compares it field by field against the block's output.
// ----------------------------------------------------------------------------
module wola_fold_checker
    import wafold_pkg::*;
#(
    parameter int MAX_FFT_LEN    = 1024,
    parameter int MAX_WINDOW_LEN = 8192,
    parameter int HISTORY_DEPTH  = 16384
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [MODE_W-1:0]          s_mode,
    input  logic [COEF_IDX_W-1:0]      s_coef_index,
    input  logic signed [SAMPLE_W-1:0] s_coef_value,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    input  logic [BIN_W-1:0]           s_bin_index,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_kind,
    input  logic [BIN_W-1:0]           m_bin_number,
    input  logic signed [FOLD_W-1:0]   m_fold_value,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         fail_count,
    output int                         pending_count
);

    typedef struct {
        logic                     kind;
        logic [BIN_W-1:0]         bin;
        logic signed [FOLD_W-1:0] value;
    } fold_beat_t;

    fold_beat_t due_beats[$];

    logic signed [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];
    logic signed [SAMPLE_W-1:0] win_mem  [MAX_WINDOW_LEN];

    logic [3:0] fft_l2;
    logic [1:0] ratio_l2;
    logic [2:0] ovl_l2;

    int unsigned wr_ptr;
    int unsigned hop_fill;
    int unsigned frame_phase;
    int unsigned last_rot;
    int unsigned frame_end;

    task automatic report(input string msg);
        fail_count++;
        $display("%0t: %s", $time, msg);
    endtask

    always @(posedge aclk) begin : track
        int unsigned n, w, hop, term, pos;
        longint      acc;
        fold_beat_t  beat, want;
        if (!aresetn) begin
            fft_l2   = FFT_L2_RST;
            ratio_l2 = RATIO_L2_RST;
            ovl_l2   = OVL_L2_RST;
            foreach (hist_mem[i])
                hist_mem[i] = '0;
            wr_ptr      = 0;
            hop_fill    = 0;
            frame_phase = 0;
            last_rot    = 0;
            frame_end   = 0;
            due_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FFT_LEN_LOG2:      fft_l2   = cfg_data[3:0];
                    CFG_WINDOW_RATIO_LOG2: ratio_l2 = cfg_data[1:0];
                    CFG_OVERLAP_LOG2:      ovl_l2   = cfg_data[2:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                n = 32'd1 << fft_l2;
                if (n > MAX_FFT_LEN)
                    n = MAX_FFT_LEN;
                case (s_mode)
                    MODE_LOAD: begin
                        if (s_coef_index < MAX_WINDOW_LEN)
                            win_mem[s_coef_index] = s_coef_value;
                    end
                    MODE_PUSH: begin
                        hop = n >> ovl_l2;
                        if (hop == 0)
                            hop = 1;
                        hist_mem[wr_ptr % HISTORY_DEPTH] = s_sample_value;
                        wr_ptr      = (wr_ptr + 1) % HISTORY_DEPTH;
                        frame_phase = ((frame_phase % n) + 1) % n;
                        hop_fill++;
                        // a shrunken hop fires on the first push past it
                        if (hop_fill >= hop) begin
                            hop_fill   = 0;
                            last_rot   = frame_phase;
                            frame_end  = wr_ptr;
                            beat.kind  = KIND_NOTE;
                            beat.bin   = '0;
                            beat.value = '0;
                            due_beats.push_back(beat);
                        end
                    end
                    MODE_READ: begin
                        w = n << ratio_l2;
                        if (w > MAX_WINDOW_LEN)
                            w = MAX_WINDOW_LEN;
                        if (w > HISTORY_DEPTH)
                            w = HISTORY_DEPTH;
                        acc = 0;
                        if (s_bin_index < n) begin
                            term = (s_bin_index + n - last_rot % n) % n;
                            // x[w-1] is the newest sample of the last frame
                            while (term < w) begin
                                pos = (frame_end % HISTORY_DEPTH + HISTORY_DEPTH - w + term)
                                      % HISTORY_DEPTH;
                                acc += longint'(win_mem[term]) * longint'(hist_mem[pos]);
                                term += n;
                            end
                        end
                        if (acc > longint'(FOLD_MAX))
                            acc = longint'(FOLD_MAX);
                        if (acc < longint'(FOLD_MIN))
                            acc = longint'(FOLD_MIN);
                        beat.kind  = KIND_FOLD;
                        beat.bin   = s_bin_index;
                        beat.value = acc[FOLD_W-1:0];
                        due_beats.push_back(beat);
                    end
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (due_beats.size() == 0) begin
                    report($sformatf("unexpected result beat: kind %0d bin %0d value %0d",
                                     m_kind, m_bin_number, m_fold_value));
                end else begin
                    want = due_beats.pop_front();
                    if (m_kind !== want.kind)
                        report($sformatf("kind mismatch: got %0d, want %0d",
                                         m_kind, want.kind));
                    if (m_bin_number !== want.bin)
                        report($sformatf("bin mismatch: got %0d, want %0d",
                                         m_bin_number, want.bin));
                    if (m_fold_value !== want.value)
                        report($sformatf("fold mismatch on bin %0d: got %0d, want %0d",
                                         want.bin, m_fold_value, want.value));
                end
            end
        end
        pending_count = due_beats.size();
    end

endmodule

// ----- dv/wola_analysis_fold_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wola_analysis_fold_top_tb
// Drives window loads, sample pushes and bin reads through a series of
// register settings, with random gaps and output stalls; a checker beside
// the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module wola_analysis_fold_top_tb;
    import wafold_pkg::*;

    localparam int MAX_FFT       = 1024;
    localparam int MAX_WIN       = 8192;
    localparam int HIST_DEPTH    = 16384;
    localparam int PHASE_ITEMS   = 30;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 24;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [MODE_W-1:0]          s_mode;
    logic [COEF_IDX_W-1:0]      s_coef_index;
    logic signed [SAMPLE_W-1:0] s_coef_value;
    logic signed [SAMPLE_W-1:0] s_sample_value;
    logic [BIN_W-1:0]           s_bin_index;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_kind;
    logic [BIN_W-1:0]           m_bin_number;
    logic signed [FOLD_W-1:0]   m_fold_value;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int fail_count;
    int pending_count;

    bit coef_loaded [MAX_WIN];
    bit s_calm;
    bit m_calm;

    wola_analysis_fold_top #(
        .MAX_FFT_LEN   (MAX_FFT),
        .MAX_WINDOW_LEN(MAX_WIN),
        .HISTORY_DEPTH (HIST_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_coef_index  (s_coef_index),
        .s_coef_value  (s_coef_value),
        .s_sample_value(s_sample_value),
        .s_bin_index   (s_bin_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_bin_number  (m_bin_number),
        .m_fold_value  (m_fold_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    wola_fold_checker #(
        .MAX_FFT_LEN   (MAX_FFT),
        .MAX_WINDOW_LEN(MAX_WIN),
        .HISTORY_DEPTH (HIST_DEPTH)
    ) fold_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_coef_index  (s_coef_index),
        .s_coef_value  (s_coef_value),
        .s_sample_value(s_sample_value),
        .s_bin_index   (s_bin_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_bin_number  (m_bin_number),
        .m_fold_value  (m_fold_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return SAMPLE_MIN;
        if (r == 1)
            return SAMPLE_MAX;
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_beat(input logic [MODE_W-1:0] mode,
                             input logic [COEF_IDX_W-1:0] cidx,
                             input logic signed [SAMPLE_W-1:0] cval,
                             input logic signed [SAMPLE_W-1:0] sval,
                             input logic [BIN_W-1:0] bin);
        int gap;
        gap = pick_gap(s_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_coef_index   <= cidx;
        s_coef_value   <= cval;
        s_sample_value <= sval;
        s_bin_index    <= bin;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (mode == MODE_LOAD)
            coef_loaded[cidx] = 1'b1;
        @(negedge aclk);
        if ($urandom_range(0, 63) == 0)
            s_calm = !s_calm;
    endtask

    task automatic load_coef(input int idx, input logic signed [SAMPLE_W-1:0] val);
        send_beat(MODE_LOAD, COEF_IDX_W'(idx), val, SAMPLE_W'($urandom), BIN_W'($urandom));
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] val);
        send_beat(MODE_PUSH, COEF_IDX_W'($urandom), SAMPLE_W'($urandom), val,
                  BIN_W'($urandom));
    endtask

    task automatic read_bin(input int bin);
        send_beat(MODE_READ, COEF_IDX_W'($urandom), SAMPLE_W'($urandom),
                  SAMPLE_W'($urandom), BIN_W'(bin));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Drop valid, wait for every result, then let a trailing load finish
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [3:0] fft, input logic [1:0] ratio,
                             input logic [2:0] ovl);
        int n, w, hop, sent, len, k, r;
        logic [1:0] pad;
        n = 1 << fft;
        if (n > MAX_FFT)
            n = MAX_FFT;
        w = n << ratio;
        if (w > MAX_WIN)
            w = MAX_WIN;
        hop = n >> ovl;
        if (hop == 0)
            hop = 1;

        pad = 2'($urandom_range(0, 3));
        write_reg(CFG_FFT_LEN_LOG2, fft);
        write_reg(CFG_WINDOW_RATIO_LOG2, {pad, ratio});
        write_reg(CFG_OVERLAP_LOG2, {pad[0], ovl});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 15)));

        // every window tap a read can touch must hold a coefficient
        for (int i = 0; i < w; i++)
            if (!coef_loaded[i])
                load_coef(i, rand_word());

        sent = 0;
        while (sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                load_coef($urandom_range(0, MAX_WIN - 1), rand_word());
                sent++;
            end else if (r < 14) begin
                send_beat(MODE_UNUSED, COEF_IDX_W'($urandom), SAMPLE_W'($urandom),
                          SAMPLE_W'($urandom), BIN_W'($urandom));
            end else if (r < 20) begin
                read_bin($urandom_range(0, 1023));
                sent++;
            end else begin
                // frame: a run of samples, then a few bin reads
                len = $urandom_range(1, (hop > 24) ? 48 : 2 * hop);
                repeat (len) push_sample(rand_word());
                k = $urandom_range(1, 4);
                repeat (k) begin
                    if ($urandom_range(0, 4) == 0)
                        read_bin($urandom_range(0, 1023));
                    else
                        read_bin($urandom_range(0, n - 1));
                end
                sent += len + k;
            end
        end
        settle();
    endtask

    initial begin : result_sink
        int hold;
        hold    = 0;
        m_calm  = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 255) == 0)
                m_calm = !m_calm;
            if (hold == 0)
                hold = pick_gap(m_calm);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_mode         = MODE_LOAD;
        s_coef_index   = '0;
        s_coef_value   = '0;
        s_sample_value = '0;
        s_bin_index    = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_FFT_LEN_LOG2;
        cfg_data       = '0;
        s_calm         = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // One-point transform, four window taps: every in-range read sums four terms
        write_reg(CFG_FFT_LEN_LOG2, 4'd0);
        write_reg(CFG_WINDOW_RATIO_LOG2, 4'd2);
        write_reg(CFG_OVERLAP_LOG2, 4'd6);
        for (int i = 0; i < 4; i++)
            load_coef(i, SAMPLE_MIN);
        load_coef(MAX_WIN - 1, SAMPLE_MAX);
        read_bin(0);
        read_bin(1023);
        send_beat(MODE_UNUSED, '1, '1, '1, '1);
        repeat (4) push_sample(SAMPLE_MIN);
        read_bin(0);
        repeat (4) push_sample(SAMPLE_MAX);
        read_bin(0);
        settle();

        run_phase(4'd1, 2'd3, 3'd0);
        run_phase(4'd3, 2'd2, 3'd1);
        run_phase(4'd0, 2'd0, 3'd0);
        run_phase(4'd5, 2'd1, 3'd7);
        run_phase(4'd6, 2'd3, 3'd2);
        run_phase(4'd12, 2'd0, 3'd3);
        run_phase(4'd2, 2'd1, 3'd0);
        run_phase(4'd15, 2'd0, 3'd7);
        run_phase(4'd10, 2'd0, 3'd6);
        // keep the window within the taps already loaded
        run_phase(4'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                  3'($urandom_range(0, 7)));

        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
